// ===== rtl/core/lagrange_interpolation_core_defines.svh =====
// Assertion macros shared by the interpolation core.
`ifndef LAGRANGE_INTERPOLATION_CORE_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LIF_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define LIF_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define LIF_ASSERT_NOW(label, pre, post)
`define LIF_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/core/lif_pkg.sv =====
package lif_pkg;
	localparam int MAX_POINTS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_EVAL  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return sat32(64'(d));
	endfunction
endpackage

// ===== rtl/core/lif_div.sv =====
module lif_div import lif_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               busy,
	output logic signed [63:0] quotient
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] a_q;
	logic [31:0] rem_q;
	logic [31:0] d_q;
	logic        neg_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q, a_q[63]};
	assign diff = {1'b0, shifted} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend[63] ? 64'(-dividend) : 64'(dividend);
			d_q <= divisor[31] ? 32'(-divisor) : 32'(divisor);
			neg_q <= dividend[63] ^ divisor[31];
			rem_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[62:0], ~diff[33]};
			rem_q <= diff[33] ? shifted[31:0] : diff[31:0];
		end
	end

	assign busy = busy_q;
	assign quotient = neg_q ? -$signed(a_q) : $signed(a_q);
endmodule

// ===== rtl/core/lagrange_interpolation_core.sv =====
// Lagrange interpolation core.
// Input channel (in_valid/in_ready) carries action, x_value and y_value in
// signed Q16.16. A load item appends a node, a clear item empties the table,
// and an evaluate item produces one result item on the output channel
// (out_valid/out_ready) with value, status, points_used and overflowed.
// Load, clear and unused actions give no result.
// An evaluation of n nodes first checks every node pair for equal abscissas,
// then makes n*(n-1) uses of the shared one-bit-per-cycle divider plus the
// shared 32x32 multiplier; in_ready is low for the whole evaluation.
// An empty table gives a result with no work; equal abscissas end the
// evaluation as soon as the duplicate check finds them.
// The result sits in an output register; while the receiver stalls, further
// loads and clears are taken, but a new evaluation waits at the end of its
// work until the earlier result item has been taken.
// Reset empties the table and clears the overflow flag; the node stores
// themselves are not cleared and need no clearing pass.
`include "lagrange_interpolation_core_defines.svh"
module lagrange_interpolation_core import lif_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [1:0]         status,
	output logic [4:0]         points_used,
	output logic               overflowed
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] RND = ONE - 64'sd1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DCHK_W = 4'd1;
	localparam logic [3:0] S_DCHK   = 4'd2;
	localparam logic [3:0] S_E_W    = 4'd3;
	localparam logic [3:0] S_E_STEP = 4'd4;
	localparam logic [3:0] S_E_MUL  = 4'd5;
	localparam logic [3:0] S_E_DST  = 4'd6;
	localparam logic [3:0] S_E_DWT  = 4'd7;
	localparam logic [3:0] S_E_Y    = 4'd8;
	localparam logic [3:0] S_E_ACC  = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic signed [31:0] node_x [MAX_POINTS];
	logic signed [31:0] node_y [MAX_POINTS];

	logic [3:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic               ovf_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      j_q;
	logic signed [31:0] xi_q;
	logic signed [31:0] xj_q;
	logic signed [31:0] yi_q;
	logic signed [31:0] xp_q;
	logic signed [31:0] f_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic [1:0]         res_st_q;
	logic               out_valid_q;
	logic signed [31:0] value_q;
	logic [1:0]         status_q;
	logic [4:0]         pts_q;
	logic               ovf_out_q;

	logic               accept;
	logic [CW-1:0]      last;
	logic               j_last;
	logic               i_last;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod_tr;
	logic signed [31:0] den;
	logic               div_start;
	logic               div_busy;
	logic signed [63:0] div_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign last = cnt_q - CW'(1);
	assign j_last = (CW'(j_q) == last);
	assign i_last = (CW'(i_q) == last);
	assign mul_b = (state_q == S_E_Y) ? yi_q : sat_diff(xp_q, xj_q);
	assign prod_tr = (prod_q + (prod_q[63] ? RND : 64'sd0)) >>> FRAC_BITS;
	assign den = sat_diff(xi_q, xj_q);
	assign div_start = (state_q == S_E_DST) && (den != 32'sd0);

	lif_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (64'(f_q) <<< FRAC_BITS),
		.divisor  (den),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (accept && action == ACT_LOAD && cnt_q < CW'(MAX_POINTS)) begin
			node_x[cnt_q[AW-1:0]] <= x_value;
			node_y[cnt_q[AW-1:0]] <= y_value;
		end
		xi_q <= node_x[i_q];
		xj_q <= node_x[j_q];
		yi_q <= node_y[i_q];
		prod_q <= 64'(f_q) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_LOAD: begin
								if (cnt_q < CW'(MAX_POINTS)) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							ACT_CLEAR: begin
								cnt_q <= '0;
								ovf_q <= 1'b0;
							end
							ACT_EVAL: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q <= S_DONE;
								end else if (cnt_q == CW'(1)) begin
									res_st_q <= ST_OK;
									state_q <= S_E_W;
								end else begin
									res_st_q <= ST_OK;
									state_q <= S_DCHK_W;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DCHK_W: state_q <= S_DCHK;
				S_DCHK: begin
					if (xi_q == xj_q) begin
						res_st_q <= ST_DUP;
						state_q <= S_DONE;
					end else if (!j_last) begin
						state_q <= S_DCHK_W;
					end else if (CW'(i_q) + CW'(2) < cnt_q) begin
						state_q <= S_DCHK_W;
					end else begin
						state_q <= S_E_W;
					end
				end
				S_E_W: state_q <= S_E_STEP;
				S_E_STEP: begin
					if (i_q == j_q) begin
						state_q <= j_last ? S_E_Y : S_E_W;
					end else begin
						state_q <= S_E_MUL;
					end
				end
				S_E_MUL: state_q <= S_E_DST;
				S_E_DST: begin
					if (den != 32'sd0) begin
						state_q <= S_E_DWT;
					end else begin
						state_q <= j_last ? S_E_Y : S_E_W;
					end
				end
				S_E_DWT: begin
					if (!div_busy) begin
						state_q <= j_last ? S_E_Y : S_E_W;
					end
				end
				S_E_Y: state_q <= S_E_ACC;
				S_E_ACC: state_q <= i_last ? S_DONE : S_E_W;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				xp_q <= x_value;
				i_q <= '0;
				j_q <= (cnt_q == CW'(1)) ? AW'(0) : AW'(1);
				f_q <= ONE[31:0];
				acc_q <= '0;
			end
			S_DCHK: begin
				if (!j_last) begin
					j_q <= j_q + AW'(1);
				end else if (CW'(i_q) + CW'(2) < cnt_q) begin
					i_q <= i_q + AW'(1);
					j_q <= i_q + AW'(2);
				end else begin
					i_q <= '0;
					j_q <= '0;
				end
			end
			S_E_STEP: begin
				if (i_q == j_q && !j_last) begin
					j_q <= j_q + AW'(1);
				end
			end
			S_E_MUL: f_q <= sat32(prod_tr);
			S_E_DST: begin
				if (den == 32'sd0 && !j_last) begin
					j_q <= j_q + AW'(1);
				end
			end
			S_E_DWT: begin
				if (!div_busy) begin
					f_q <= sat32(div_q);
					if (!j_last) begin
						j_q <= j_q + AW'(1);
					end
				end
			end
			S_E_ACC: begin
				acc_q <= acc_q + prod_tr;
				f_q <= ONE[31:0];
				j_q <= '0;
				if (!i_last) begin
					i_q <= i_q + AW'(1);
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					value_q <= (res_st_q == ST_OK) ? sat32(acc_q) : 32'sd0;
					status_q <= res_st_q;
					pts_q <= 5'(cnt_q);
					ovf_out_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign status = status_q;
	assign points_used = pts_q;
	assign overflowed = ovf_out_q;

	`LIF_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CW'(MAX_POINTS))
	`LIF_ASSERT_NOW(a_div_idle_start, div_start, !div_busy)
	`LIF_ASSERT_NEXT(a_done_loads, (state_q == S_DONE) && (!out_valid_q || out_ready), out_valid_q && (state_q == S_IDLE))
endmodule
